// File: sv/card_number_luhn_validator_assert.svh
// Assertion macros shared by the card number validator modules.
`ifndef CARD_NUMBER_LUHN_VALIDATOR_ASSERT_SVH
`define CARD_NUMBER_LUHN_VALIDATOR_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define CNLV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Trigger in one cycle implies the consequent in the next.
`define CNLV_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cnlv_pkg.sv
// Shared types, constants and helpers for the card number validator.
package cnlv_pkg;

    localparam int BIN_W      = 54;            // card number width
    localparam int NUM_DIGITS = 17;            // 2^54 < 10^17
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(BIN_W); // shift / digit counter
    localparam int POS_W      = 5;             // digit position, up to 17
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    localparam logic [POS_W-1:0] LEN_13 = 5'd13;
    localparam logic [POS_W-1:0] LEN_15 = 5'd15;
    localparam logic [POS_W-1:0] LEN_16 = 5'd16;
    localparam logic [3:0]       LEAD_3 = 4'd3;
    localparam logic [3:0]       LEAD_4 = 4'd4;
    localparam logic [3:0]       LEAD_5 = 4'd5;

    typedef enum logic [2:0] {
        ST_BAD_LEN    = 3'd0,
        ST_CHECK_FAIL = 3'd1,
        ST_BRAND3     = 3'd2,
        ST_BRAND5     = 3'd3,
        ST_BRAND4     = 3'd4,
        ST_VALID      = 3'd5
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // take a new card number
        logic shift;    // one double-dabble step
        logic scan;     // consume one BCD digit
        logic publish;  // move result into the output register
    } cnlv_cmd_t;

    // Luhn term of one digit; odd positions are doubled and folded.
    function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic odd);
        logic [4:0] dbl;
        dbl = {d, 1'b0};
        if (!odd)
            return d;
        else if (dbl > 5'd9)
            return 4'(dbl - 5'd9);
        else
            return dbl[3:0];
    endfunction

endpackage

// File: sv/card_number_luhn_validator.sv
// Top level: Luhn mod 10 card number validator on stream ports.
// From an accepted request: the double-dabble shifts, the digit scan, then
//   the move into the output register, which waits while a result is held.
// A new request is taken only in IDLE, after the last result is published.
// A finished result holds in the output register while the next request runs.
// Reset: rst_n asynchronous, active low; clears the sequencer and the output.
module card_number_luhn_validator
    import cnlv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request side
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [53:0] card_number, [55:54] zero
    // result side
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [2:0] status, [7:3] digit_count,
                                              // [8] checksum_ok, [15:9] zero
);

    cnlv_cmd_t  cmd;
    logic [2:0] status;
    logic [4:0] digit_count;
    logic       checksum_ok;

    // sequencer: one shared shift / digit counter
    cnlv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // BCD conversion, Luhn sum, brand decode
    cnlv_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .card_number (s_tdata[BIN_W-1:0]),
        .status      (status),
        .digit_count (digit_count),
        .checksum_ok (checksum_ok)
    );

    assign m_tdata = {7'd0, checksum_ok, digit_count, status};

endmodule

// File: sv/cnlv_ctrl.sv
// Sequencer for the card number validator: conversion, digit scan, output.
module cnlv_ctrl
    import cnlv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output cnlv_cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE,
        CONV,
        SCAN,
        PUBL
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;

    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(BIN_W - 1);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_DIGITS - 1);

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = CONV;
                end
            end
            CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                cmd.scan = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_LAST)
                    state_next = PUBL;
            end
            PUBL:
            begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.publish   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end
            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`include "card_number_luhn_validator_assert.svh"

    `CNLV_ASSERT_ALWAYS(a_publish_free, !cmd.publish || !m_tvalid_reg || m_tready, "result overwritten")
    `CNLV_ASSERT_NEXT(a_accept_conv, s_tvalid && s_tready, state_reg == CONV && cnt_reg == '0, "accept did not start conversion")
    `CNLV_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "conflicting datapath commands")

endmodule

// File: sv/cnlv_dp.sv
// Datapath: serial binary to BCD, Luhn digit scan and result register.
module cnlv_dp
    import cnlv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cnlv_cmd_t        cmd,
    input  logic [BIN_W-1:0] card_number,
    output logic [2:0]       status,
    output logic [4:0]       digit_count,
    output logic             checksum_ok
);

    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic [3:0]       lead_reg, lead_next;
    logic [3:0]       sum_reg, sum_next;

    logic [2:0]       status_reg, status_next;
    logic [4:0]       digit_count_reg;
    logic             checksum_ok_reg;

    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       digit;
    logic [4:0]       sum_raw;
    logic             ok;

    // add-3 on every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign digit   = bcd_reg[3:0];
    assign sum_raw = {1'b0, sum_reg} + {1'b0, luhn_term(digit, pos_reg[0])};
    assign ok      = (sum_reg == 4'd0);

    always_comb
    begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        lead_next  = lead_reg;
        sum_next   = sum_reg;
        if (cmd.load)
        begin
            bin_next   = card_number;
            bcd_next   = '0;
            pos_next   = '0;
            count_next = '0;
            lead_next  = '0;
            sum_next   = '0;
        end
        else if (cmd.shift)
        begin
            {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
        end
        else if (cmd.scan)
        begin
            bcd_next = {4'd0, bcd_reg[BCD_W-1:4]};
            pos_next = pos_reg + 1'b1;
            sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
            if (digit != 4'd0)
            begin
                count_next = pos_reg + 1'b1;
                lead_next  = digit;
            end
        end
    end

    always_comb
    begin
        if (count_reg != LEN_13 && count_reg != LEN_15 && count_reg != LEN_16)
            status_next = ST_BAD_LEN;
        else if (!ok)
            status_next = ST_CHECK_FAIL;
        else if (lead_reg == LEAD_3 && count_reg == LEN_15)
            status_next = ST_BRAND3;
        else if (lead_reg == LEAD_5 && count_reg == LEN_16)
            status_next = ST_BRAND5;
        else if (lead_reg == LEAD_4 && (count_reg == LEN_13 || count_reg == LEN_16))
            status_next = ST_BRAND4;
        else
            status_next = ST_VALID;
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        pos_reg   <= pos_next;
        count_reg <= count_next;
        lead_reg  <= lead_next;
        sum_reg   <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= ST_BAD_LEN;
            digit_count_reg <= '0;
            checksum_ok_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            status_reg      <= status_next;
            digit_count_reg <= count_reg;
            checksum_ok_reg <= ok;
        end
    end

    assign status      = status_reg;
    assign digit_count = digit_count_reg;
    assign checksum_ok = checksum_ok_reg;

`include "card_number_luhn_validator_assert.svh"

    `CNLV_ASSERT_ALWAYS(a_count_range, digit_count_reg <= 5'(NUM_DIGITS), "digit count out of range")
    `CNLV_ASSERT_ALWAYS(a_len_status, status_reg == ST_BAD_LEN || digit_count_reg == LEN_13 || digit_count_reg == LEN_15 || digit_count_reg == LEN_16, "length status mismatch")
    `CNLV_ASSERT_ALWAYS(a_sum_status, (status_reg == ST_CHECK_FAIL) == (status_reg != ST_BAD_LEN && !checksum_ok_reg), "checksum status mismatch")

endmodule
